@@ design/xdsu_pkg.sv @@
// ----------------------------------------------------------------------------
// xdsu_pkg: shared types and constants for the decoder signature unpacker
// Request and response layouts, status codes and the fixed signature.
// ----------------------------------------------------------------------------
package xdsu_pkg;

   localparam int SIG_BYTES  = 19;
   localparam int WIN_DEPTH  = SIG_BYTES - 1;
   localparam int FILL_WIDTH = $clog2(WIN_DEPTH + 1);
   localparam int LEN_LO_IDX = 4;
   localparam int LEN_HI_IDX = 5;

   // Bytes at the length positions are wildcards and never compared.
   localparam logic [7:0] SIGNATURE [SIG_BYTES] = '{
      8'h33, 8'hC9, 8'h66, 8'hB9, 8'h00, 8'h00, 8'hE8, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hC1, 8'h5E, 8'h30, 8'h4C, 8'h0E, 8'h07, 8'hE2, 8'hFA
   };

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] STATUS_NONE    = 2'd0;
   localparam logic [1:0] STATUS_DECODED = 2'd1;
   localparam logic [1:0] STATUS_SHORT   = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [1:0] status;
      logic       last;
   } rsp_type;

endpackage

@@ design/xor_decoder_signature_unpacker.sv @@
// ----------------------------------------------------------------------------
// xor_decoder_signature_unpacker: streaming signature search and XOR unpack
// Finds a 19-byte decoder signature in a byte stream, decodes the payload
// that follows it and reports a status at the end of each message.
// ----------------------------------------------------------------------------
//
//   channel | ports                          | carries
//   --------+--------------------------------+------------------------------
//   request | req_valid, req_stall, req_data | one message byte, end flag
//   result  | rsp_valid, rsp_stall, rsp_data | payload byte or status
//
// One request is taken per cycle; the window compare, length capture and
// XOR are done in the accepting cycle and written into a small result queue.
// A request that yields a payload byte and a status drains as two responses.
// req_stall rises only when the result queue is full (QUEUE_DEPTH entries).
// Synchronous reset returns to searching with an empty window and queue.
//
module xor_decoder_signature_unpacker #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  xdsu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output xdsu_pkg::rsp_type rsp_data
);
   import xdsu_pkg::*;

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_SEARCH  = 2'd0,
      PH_COLLECT = 2'd1,
      PH_DONE    = 2'd2
   } phase_type;

   // An entry per request with output: optional payload byte and status.
   typedef struct packed {
      logic       has_data;
      logic [7:0] data;
      logic       has_status;
      logic [1:0] status;
   } entry_type;

   phase_type             phase_ff, phase_in;
   logic [7:0]            window_ff [WIN_DEPTH];
   logic [7:0]            window_in [WIN_DEPTH];
   logic [FILL_WIDTH-1:0] fill_ff, fill_in;
   logic [15:0]           length_ff, length_in;
   logic [15:0]           count_ff, count_in;

   entry_type             queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [COUNT_W-1:0]    used_ff;
   logic                  sent_ff;

   logic                  req_fire, rsp_fire, push, pop, match;
   entry_type             entry, head;

   assign req_stall = (used_ff == COUNT_W'(QUEUE_DEPTH));
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      match = (fill_ff == FILL_WIDTH'(WIN_DEPTH)) && (req_data.in_byte == SIGNATURE[WIN_DEPTH]);
      for (int i = 0; i < WIN_DEPTH; i++) begin
         if (i != LEN_LO_IDX && i != LEN_HI_IDX && window_ff[i] != SIGNATURE[i]) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      logic [15:0] pos;
      pos       = count_ff + 16'd1;
      phase_in  = phase_ff;
      window_in = window_ff;
      fill_in   = fill_ff;
      length_in = length_ff;
      count_in  = count_ff;
      entry     = '0;
      if (req_fire) begin
         unique case (phase_ff)
            PH_COLLECT: begin
               if (count_ff < length_ff) begin
                  entry.has_data = 1'b1;
                  entry.data     = req_data.in_byte ^ pos[7:0];
                  count_in       = pos;
               end
               if (count_in >= length_ff) begin
                  phase_in = PH_DONE;
               end
            end
            PH_DONE: begin
            end
            default: begin
               if (match) begin
                  length_in = {window_ff[LEN_HI_IDX], window_ff[LEN_LO_IDX]} + 16'd1;
                  count_in  = '0;
                  phase_in  = (length_in == 16'd0) ? PH_DONE : PH_COLLECT;
               end else begin
                  for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                     window_in[i] = window_ff[i+1];
                  end
                  window_in[WIN_DEPTH-1] = req_data.in_byte;
                  if (fill_ff < FILL_WIDTH'(WIN_DEPTH)) begin
                     fill_in = fill_ff + FILL_WIDTH'(1);
                  end
               end
            end
         endcase
         if (req_data.end_of_message) begin
            entry.has_status = 1'b1;
            if (phase_in == PH_COLLECT || phase_in == PH_DONE) begin
               entry.status = (count_in >= length_in) ? STATUS_DECODED : STATUS_SHORT;
            end else begin
               entry.status = STATUS_NONE;
            end
            // start the next message from scratch
            phase_in  = PH_SEARCH;
            fill_in   = '0;
            length_in = '0;
            count_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      if (reset) begin
         phase_ff  <= PH_SEARCH;
         fill_ff   <= '0;
         length_ff <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         fill_ff   <= fill_in;
         length_ff <= length_in;
         count_ff  <= count_in;
      end
   end

   // Result queue
   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_valid = (used_ff != '0);
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign push      = req_fire && (entry.has_data || entry.has_status);

   always_comb begin
      rsp_data = '0;
      if (head.has_data && !sent_ff) begin
         rsp_data.kind = KIND_DATA;
         rsp_data.data = head.data;
         rsp_data.last = !head.has_status;
      end else begin
         rsp_data.kind   = KIND_STATUS;
         rsp_data.status = head.status;
         rsp_data.last   = 1'b1;
      end
   end

   // Hold the entry after its payload byte when a status still follows.
   assign pop = rsp_fire && rsp_data.last;

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
         sent_ff   <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            used_ff <= used_ff + COUNT_W'(1);
         end else if (pop && !push) begin
            used_ff <= used_ff - COUNT_W'(1);
         end
         if (rsp_fire) begin
            sent_ff <= !rsp_data.last;
         end
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= COUNT_W'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_sent_split: assert property (@(posedge clock) disable iff (reset)
      sent_ff |-> (rsp_valid && head.has_data && head.has_status))
      else $error("split flag set without a pending status");

   a_collect_open: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_COLLECT) |-> (count_ff < length_ff))
      else $error("collecting with payload already complete");

   a_eom_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.end_of_message) |=> (phase_ff == PH_SEARCH && fill_ff == '0))
      else $error("state not cleared after end of message");

   a_eom_status: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.end_of_message) |-> push)
      else $error("end of message without a status entry");

endmodule

@@ tb/sv/xor_decoder_signature_unpacker_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_decoder_signature_unpacker_tb: self-checking bench for the unpacker
// Streams messages byte by byte through the request channel. A behavioral
// copy of the unpacker predicts every payload byte and status; each result
// is compared field by field in order. Both channels idle and stall at
// random, with one stretch of full-rate traffic.
// ----------------------------------------------------------------------------
module xor_decoder_signature_unpacker_tb;
   import xdsu_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 400;
   localparam int DRAIN_CYCLES = 6;

   typedef enum logic [1:0] {SCANNING, UNPACKING, FINISHED} scan_phase_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // predicted unpacker state
   logic [7:0]            sig_window [WIN_DEPTH];
   logic [FILL_WIDTH-1:0] window_count;
   scan_phase_type        scan_phase;
   logic [15:0]           payload_len;
   logic [15:0]           payload_pos;

   rsp_type unpack_results [$];
   int      error_count = 0;
   int      sent_count  = 0;
   bit      idle_on     = 1'b1;

   xor_decoder_signature_unpacker u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic clear_unpacker();
      for (int i = 0; i < WIN_DEPTH; i++) sig_window[i] = 8'h00;
      window_count = '0;
      scan_phase   = SCANNING;
      payload_len  = 16'h0000;
      payload_pos  = 16'h0000;
   endtask

   task automatic unpack_step(input req_type r);
      rsp_type    item;
      logic       hit;
      logic [1:0] st;
      if (scan_phase == UNPACKING) begin
         if (payload_pos < payload_len) begin
            payload_pos = payload_pos + 16'd1;
            item = '{kind: KIND_DATA, data: r.in_byte ^ payload_pos[7:0],
                     status: STATUS_NONE, last: !r.end_of_message};
            unpack_results.push_back(item);
         end
         if (payload_pos >= payload_len) scan_phase = FINISHED;
      end else if (scan_phase != FINISHED) begin
         hit = (window_count == WIN_DEPTH) && (r.in_byte == SIGNATURE[WIN_DEPTH]);
         for (int i = 0; i < WIN_DEPTH; i++) begin
            if (i != LEN_LO_IDX && i != LEN_HI_IDX && sig_window[i] != SIGNATURE[i])
               hit = 1'b0;
         end
         if (hit) begin
            // length wraps: 0xFFFF plus one is an empty payload
            payload_len = {sig_window[LEN_HI_IDX], sig_window[LEN_LO_IDX]} + 16'd1;
            payload_pos = 16'h0000;
            scan_phase  = (payload_len == 16'h0000) ? FINISHED : UNPACKING;
         end else begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) sig_window[i] = sig_window[i+1];
            sig_window[WIN_DEPTH-1] = r.in_byte;
            if (window_count < WIN_DEPTH) window_count = window_count + 1'b1;
         end
      end
      if (r.end_of_message) begin
         if (scan_phase == SCANNING)
            st = STATUS_NONE;
         else
            st = (payload_pos >= payload_len) ? STATUS_DECODED : STATUS_SHORT;
         item = '{kind: KIND_STATUS, data: 8'h00, status: st, last: 1'b1};
         unpack_results.push_back(item);
         clear_unpacker();
      end
   endtask

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 60) $display("mismatch: %s", what);
   endtask

   // predict on each accepted request, then check each accepted response
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) unpack_step(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (unpack_results.size() == 0) begin
               report_mismatch($sformatf("unexpected response %p", rsp_data));
            end else begin
               want = unpack_results.pop_front();
               if (rsp_data.kind !== want.kind)
                  report_mismatch($sformatf("kind %b, want %b", rsp_data.kind, want.kind));
               if (rsp_data.data !== want.data)
                  report_mismatch($sformatf("data %h, want %h", rsp_data.data, want.data));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.last !== want.last)
                  report_mismatch($sformatf("last %b, want %b", rsp_data.last, want.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < 30);
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   task automatic send_request(input logic [7:0] b, input logic eom);
      if (idle_on && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: b, end_of_message: eom};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_message(input logic [7:0] msg [$]);
      foreach (msg[i]) send_request(msg[i], i == msg.size() - 1);
   endtask

   task automatic add_signature(ref logic [7:0] msg [$], input logic [7:0] len_lo,
                                input logic [7:0] len_hi);
      for (int i = 0; i < SIG_BYTES; i++) begin
         if (i == LEN_LO_IDX)
            msg.push_back(len_lo);
         else if (i == LEN_HI_IDX)
            msg.push_back(len_hi);
         else
            msg.push_back(SIGNATURE[i]);
      end
   endtask

   task automatic test_no_signature();
      logic [7:0] msg [$];
      msg = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
      send_message(msg);
      msg = '{8'hFF};
      send_message(msg);
   endtask

   task automatic test_basic_decode();
      logic [7:0] msg [$];
      // partial signature first, so the search has to restart
      msg = '{8'h33, 8'hC9, 8'h66};
      add_signature(msg, 8'h02, 8'h00);
      msg.push_back(8'h00);
      msg.push_back(8'hFF);
      msg.push_back(8'h81);
      msg.push_back(8'h77);
      send_message(msg);
   endtask

   task automatic test_later_match_ignored();
      logic [7:0] msg [$];
      add_signature(msg, 8'h13, 8'h00);
      add_signature(msg, 8'h01, 8'h00);
      msg.push_back(8'hC3);
      add_signature(msg, 8'h00, 8'h00);
      send_message(msg);
   endtask

   task automatic test_match_on_final_byte();
      logic [7:0] msg [$];
      add_signature(msg, 8'h04, 8'h00);
      send_message(msg);
      msg.delete();
      add_signature(msg, 8'hFF, 8'hFF);
      send_message(msg);
   endtask

   task automatic test_zero_length();
      logic [7:0] msg [$];
      add_signature(msg, 8'hFF, 8'hFF);
      msg.push_back(8'h12);
      msg.push_back(8'hFE);
      send_message(msg);
   endtask

   task automatic test_short_payload();
      logic [7:0] msg [$];
      msg = '{8'h01};
      add_signature(msg, 8'h08, 8'h80);
      msg.push_back(8'h3C);
      msg.push_back(8'hE1);
      send_message(msg);
   endtask

   task automatic test_random_traffic();
      logic [7:0] msg [$];
      int         roll;
      int         n;
      int         spot;
      while (sent_count < RANDOM_ITEMS) begin
         // one stretch at full rate in the middle
         idle_on = (sent_count < 220) || (sent_count > 340);
         msg.delete();
         roll = $urandom_range(99);
         if (roll < 60) begin
            repeat ($urandom_range(4)) msg.push_back(8'($urandom));
            if ($urandom_range(4) == 0)
               for (int i = 0; i < $urandom_range(8, 1); i++) msg.push_back(SIGNATURE[i]);
            n = $urandom_range(12);
            add_signature(msg, 8'(n - 1), 8'((n - 1) >> 8));
            repeat (n) msg.push_back(8'($urandom));
            repeat ($urandom_range(3)) msg.push_back(8'($urandom));
         end else if (roll < 75) begin
            // arbitrary length field, message cut after a few payload bytes
            add_signature(msg, 8'($urandom), 8'($urandom));
            repeat ($urandom_range(5)) msg.push_back(8'($urandom));
         end else if (roll < 88) begin
            add_signature(msg, 8'($urandom_range(6)), 8'h00);
            do spot = $urandom_range(SIG_BYTES - 1);
            while (spot == LEN_LO_IDX || spot == LEN_HI_IDX);
            msg[spot] = 8'($urandom);
            repeat ($urandom_range(4)) msg.push_back(8'($urandom));
         end else begin
            repeat ($urandom_range(8, 1)) msg.push_back(8'($urandom));
         end
         send_message(msg);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      clear_unpacker();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_no_signature();
      test_basic_decode();
      test_later_match_ignored();
      test_match_on_final_byte();
      test_zero_length();
      test_short_payload();
      test_random_traffic();
      req_valid <= 1'b0;
      while (unpack_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ xor_decoder_signature_unpacker.f @@
design/xdsu_pkg.sv
design/xor_decoder_signature_unpacker.sv
tb/sv/xor_decoder_signature_unpacker_tb.sv
